/* sv/tfn_pkg.sv */
// Package for the triangle face normal block.
// Holds default sizes, the reduced magnitude width and the sideband type.
// Used by triangle_face_normal_top and tfn_checker.
package tfn_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int NORMAL_FRAC = 15;
	localparam int REDUCED_BITS = 24;

	typedef struct packed {
		logic [2:0][REDUCED_BITS-1:0] r;
		logic [2:0]                   sgn;
		logic                         deg;
	} side_t;

endpackage

/* sv/triangle_face_normal_top.sv */
// Top level of the triangle face normal block.
// Depends on tfn_pkg for defaults and the sideband type.
//
// Usage: one beat on the input channel carries the three corners of a face
// (a_*, b_*, c_*, signed Q8.8). One beat on the output channel carries the
// unit normal (normal_*, signed Q1.15, magnitude at most 2^NORMAL_FRAC - 1)
// and the degenerate flag, which is set with a zero normal when the cross
// product is zero. Beats leave in the order they arrive.
// The pipeline has seven stages for edges, products, cross product, shift
// search, shift, squares and sum, then one stage per root bit of the square
// root (REDUCED_BITS + 1), one stage that forms the dividends, one stage per
// quotient bit of the three parallel dividers (NORMAL_FRAC + 1), and the
// output register.
// Throughput is one beat per cycle while the receiver does not stall.
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls while a result is shown, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is lost or repeated.
module triangle_face_normal_top #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH,
	parameter int NORMAL_FRAC = tfn_pkg::NORMAL_FRAC
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] a_z,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] b_z,
	input  logic signed [COORD_WIDTH-1:0] c_x,
	input  logic signed [COORD_WIDTH-1:0] c_y,
	input  logic signed [COORD_WIDTH-1:0] c_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [NORMAL_FRAC:0]   normal_x,
	output logic signed [NORMAL_FRAC:0]   normal_y,
	output logic signed [NORMAL_FRAC:0]   normal_z,
	output logic                          degenerate
);

	localparam int EW = COORD_WIDTH + 1;
	localparam int PW = 2 * EW;
	localparam int NW = PW + 1;
	localparam int MAGW = NW - 1;
	localparam int RB = tfn_pkg::REDUCED_BITS;
	localparam int SQ = RB + 1;
	localparam int SUMW = 2 * SQ;
	localparam int RW = SQ + 3;
	localparam int SW = $clog2(MAGW + 1);
	localparam int QW = NORMAL_FRAC + 1;
	localparam int DW = RB + NORMAL_FRAC + 1;

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [EW-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [PW-1:0] p_s2 [6];
	logic [MAGW-1:0] mag_s3 [3];
	logic [MAGW-1:0] mag_s4 [3];
	logic [2:0] sgn_s3, sgn_s4, sgn_s5, sgn_s6;
	logic deg_s3, deg_s4, deg_s5, deg_s6;
	logic [SW-1:0] sh_s4;
	logic [RB-1:0] r_s5 [3];
	logic [RB-1:0] r_s6 [3];
	logic [SUMW-1:0] sqr_s6 [3];
	logic [SUMW-1:0] sum_s7;
	tfn_pkg::side_t side_s7;

	logic signed [NW-1:0] n_c [3];
	logic [MAGW-1:0] mor_c;
	logic [SW-1:0] sh_c;

	always_comb begin
		n_c[0] = NW'(p_s2[0]) - NW'(p_s2[1]);
		n_c[1] = NW'(p_s2[2]) - NW'(p_s2[3]);
		n_c[2] = NW'(p_s2[4]) - NW'(p_s2[5]);
		mor_c = mag_s3[0] | mag_s3[1] | mag_s3[2];
		sh_c = '0;
		for (int i = RB; i < MAGW; i++) begin
			if (mor_c[i]) sh_c = SW'(i - RB + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s1 <= EW'(b_x) - EW'(a_x);
			e1y_s1 <= EW'(b_y) - EW'(a_y);
			e1z_s1 <= EW'(b_z) - EW'(a_z);
			e2x_s1 <= EW'(c_x) - EW'(a_x);
			e2y_s1 <= EW'(c_y) - EW'(a_y);
			e2z_s1 <= EW'(c_z) - EW'(a_z);

			p_s2[0] <= PW'(e1y_s1) * PW'(e2z_s1);
			p_s2[1] <= PW'(e1z_s1) * PW'(e2y_s1);
			p_s2[2] <= PW'(e1z_s1) * PW'(e2x_s1);
			p_s2[3] <= PW'(e1x_s1) * PW'(e2z_s1);
			p_s2[4] <= PW'(e1x_s1) * PW'(e2y_s1);
			p_s2[5] <= PW'(e1y_s1) * PW'(e2x_s1);

			for (int k = 0; k < 3; k++) begin
				mag_s3[k] <= n_c[k][NW-1] ? MAGW'(-n_c[k]) : MAGW'(n_c[k]);
				sgn_s3[k] <= n_c[k][NW-1];
			end
			deg_s3 <= (n_c[0] == '0) && (n_c[1] == '0) && (n_c[2] == '0);

			mag_s4 <= mag_s3;
			sh_s4 <= sh_c;
			sgn_s4 <= sgn_s3;
			deg_s4 <= deg_s3;

			for (int k = 0; k < 3; k++) begin
				r_s5[k] <= RB'(mag_s4[k] >> sh_s4);
			end
			sgn_s5 <= sgn_s4;
			deg_s5 <= deg_s4;

			for (int k = 0; k < 3; k++) begin
				sqr_s6[k] <= SUMW'(r_s5[k]) * SUMW'(r_s5[k]);
			end
			r_s6 <= r_s5;
			sgn_s6 <= sgn_s5;
			deg_s6 <= deg_s5;

			sum_s7 <= sqr_s6[0] + sqr_s6[1] + sqr_s6[2];
			side_s7.r[0] <= r_s6[0];
			side_s7.r[1] <= r_s6[1];
			side_s7.r[2] <= r_s6[2];
			side_s7.sgn <= sgn_s6;
			side_s7.deg <= deg_s6;
		end
	end

	logic [SUMW-1:0] sq_x_s [SQ];
	logic [RW-1:0] sq_rem_s [SQ];
	logic [SQ-1:0] sq_root_s [SQ];
	tfn_pkg::side_t sq_side_s [SQ];
	logic [SQ-1:0] sq_v_s;

	for (genvar j = 0; j < SQ; j++) begin : g_sqrt
		logic [SUMW-1:0] x_in;
		logic [RW-1:0] rem_in, rem2, trial;
		logic [SQ-1:0] root_in;
		tfn_pkg::side_t side_in;
		logic v_in;

		if (j == 0) begin : g_first
			assign x_in = sum_s7;
			assign rem_in = '0;
			assign root_in = '0;
			assign side_in = side_s7;
			assign v_in = v_s7;
		end else begin : g_next
			assign x_in = sq_x_s[j-1];
			assign rem_in = sq_rem_s[j-1];
			assign root_in = sq_root_s[j-1];
			assign side_in = sq_side_s[j-1];
			assign v_in = sq_v_s[j-1];
		end

		assign rem2 = {rem_in[RW-3:0], x_in[SUMW-1:SUMW-2]};
		assign trial = RW'({root_in, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j] <= 1'b0;
			end else if (en) begin
				sq_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_x_s[j] <= {x_in[SUMW-3:0], 2'b00};
				sq_side_s[j] <= side_in;
				if (rem2 >= trial) begin
					sq_rem_s[j] <= rem2 - trial;
					sq_root_s[j] <= {root_in[SQ-2:0], 1'b1};
				end else begin
					sq_rem_s[j] <= rem2;
					sq_root_s[j] <= {root_in[SQ-2:0], 1'b0};
				end
			end
		end
	end

	logic [SQ-1:0] len_c;
	logic [DW-1:0] dvd_c [3];
	logic [SQ:0] dv_rem_s8 [3];
	logic [QW-1:0] dv_low_s8 [3];
	logic [SQ-1:0] len_s8;
	logic [2:0] sgn_s8;
	logic deg_s8;

	always_comb begin
		len_c = sq_root_s[SQ-1];
		for (int k = 0; k < 3; k++) begin
			dvd_c[k] = (DW'(sq_side_s[SQ-1].r[k]) << NORMAL_FRAC) + DW'(len_c >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= sq_v_s[SQ-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dv_rem_s8[k] <= (SQ + 1)'(dvd_c[k] >> QW);
				dv_low_s8[k] <= dvd_c[k][QW-1:0];
			end
			len_s8 <= len_c;
			sgn_s8 <= sq_side_s[SQ-1].sgn;
			deg_s8 <= sq_side_s[SQ-1].deg;
		end
	end

	logic [SQ:0] dv_rem_s [QW][3];
	logic [QW-1:0] dv_low_s [QW][3];
	logic [QW-1:0] dv_q_s [QW][3];
	logic [SQ-1:0] dv_len_s [QW];
	logic [2:0] dv_sgn_s [QW];
	logic [QW-1:0] dv_deg_s;
	logic [QW-1:0] dv_v_s;

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [SQ:0] rem_in [3];
		logic [QW-1:0] low_in [3];
		logic [QW-1:0] q_in [3];
		logic [SQ:0] t_c [3];
		logic [SQ-1:0] len_in;
		logic [2:0] sgn_in;
		logic deg_in, v_in;

		if (j == 0) begin : g_first
			assign rem_in = dv_rem_s8;
			assign low_in = dv_low_s8;
			assign q_in = '{default: '0};
			assign len_in = len_s8;
			assign sgn_in = sgn_s8;
			assign deg_in = deg_s8;
			assign v_in = v_s8;
		end else begin : g_next
			assign rem_in = dv_rem_s[j-1];
			assign low_in = dv_low_s[j-1];
			assign q_in = dv_q_s[j-1];
			assign len_in = dv_len_s[j-1];
			assign sgn_in = dv_sgn_s[j-1];
			assign deg_in = dv_deg_s[j-1];
			assign v_in = dv_v_s[j-1];
		end

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				t_c[k] = {rem_in[k][SQ-1:0], low_in[k][QW-1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					dv_low_s[j][k] <= {low_in[k][QW-2:0], 1'b0};
					if (t_c[k] >= {1'b0, len_in}) begin
						dv_rem_s[j][k] <= t_c[k] - {1'b0, len_in};
						dv_q_s[j][k] <= {q_in[k][QW-2:0], 1'b1};
					end else begin
						dv_rem_s[j][k] <= t_c[k];
						dv_q_s[j][k] <= {q_in[k][QW-2:0], 1'b0};
					end
				end
				dv_len_s[j] <= len_in;
				dv_sgn_s[j] <= sgn_in;
				dv_deg_s[j] <= deg_in;
			end
		end
	end

	logic [QW-1:0] sat_c [3];
	logic [QW-1:0] res_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sat_c[k] = dv_q_s[QW-1][k][QW-1] ? {1'b0, {NORMAL_FRAC{1'b1}}} : dv_q_s[QW-1][k];
			if (dv_deg_s[QW-1]) begin
				res_c[k] = '0;
			end else if (dv_sgn_s[QW-1][k]) begin
				res_c[k] = -sat_c[k];
			end else begin
				res_c[k] = sat_c[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			normal_x <= res_c[0];
			normal_y <= res_c[1];
			normal_z <= res_c[2];
			degenerate <= dv_deg_s[QW-1];
		end
	end

endmodule

/* sv/tfn_checker.sv */
// Port-level checker for the triangle face normal block.
// Depends on tfn_pkg for defaults; bound to triangle_face_normal_top below.
module tfn_checker #(
	parameter int NORMAL_FRAC = tfn_pkg::NORMAL_FRAC
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic signed [NORMAL_FRAC:0] normal_x,
	input logic signed [NORMAL_FRAC:0] normal_y,
	input logic signed [NORMAL_FRAC:0] normal_z,
	input logic                        degenerate
);

	localparam logic [NORMAL_FRAC:0] MostNeg = {1'b1, {NORMAL_FRAC{1'b0}}};

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output beat shown during reset");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output is free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled output beat dropped");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
		else $error("degenerate face with nonzero normal");

	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (normal_x != MostNeg && normal_y != MostNeg && normal_z != MostNeg))
		else $error("normal component outside saturation range");

endmodule

bind triangle_face_normal_top tfn_checker #(.NORMAL_FRAC(NORMAL_FRAC)) u_tfn_checker (.*);

/* tb/tb_triangle_face_normal_top.sv */
// Testbench for triangle_face_normal_top: drives faces with random idling on both
// channels and checks every normal against a predictor of the cross product normalization.
// Depends on tfn_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_triangle_face_normal_top;

	localparam int CW = tfn_pkg::COORD_WIDTH;
	localparam int NF = tfn_pkg::NORMAL_FRAC;
	localparam int LATENCY = 35 + NF;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct packed {
		logic signed [NF:0] nx;
		logic signed [NF:0] ny;
		logic signed [NF:0] nz;
		logic deg;
	} normal_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	coord_t a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic out_valid;
	logic out_stall;
	logic signed [NF:0] normal_x, normal_y, normal_z;
	logic degenerate;

	normal_t pending_normals[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	longint cycles = 0;

	triangle_face_normal_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z), .out_valid(out_valid), .out_stall(out_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic normal_t face_normal(coord_t ax, coord_t ay, coord_t az, coord_t bx,
			coord_t by, coord_t bz, coord_t cx, coord_t cy, coord_t cz);
		longint e1x, e1y, e1z, e2x, e2y, e2z;
		longint n[3];
		longint unsigned r[3];
		longint unsigned m, sum, len, q;
		logic signed [NF:0] comp[3];
		normal_t res;
		int s;
		e1x = longint'(bx) - ax; e1y = longint'(by) - ay; e1z = longint'(bz) - az;
		e2x = longint'(cx) - ax; e2y = longint'(cy) - ay; e2z = longint'(cz) - az;
		n[0] = e1y * e2z - e1z * e2y;
		n[1] = e1z * e2x - e1x * e2z;
		n[2] = e1x * e2y - e1y * e2x;
		if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
			res = '0;
			res.deg = 1'b1;
			return res;
		end
		m = 0;
		for (int i = 0; i < 3; i++) begin
			r[i] = n[i] < 0 ? longint'(-n[i]) : n[i];
			if (r[i] > m) m = r[i];
		end
		s = 0;
		while ((m >> s) >= (64'd1 << tfn_pkg::REDUCED_BITS)) s++;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			r[i] >>= s;
			sum += r[i] * r[i];
		end
		len = int_sqrt(sum);
		if (len == 0) len = 1;
		for (int i = 0; i < 3; i++) begin
			q = ((r[i] << NF) + (len >> 1)) / len;
			if (q > (64'd1 << NF) - 1) q = (64'd1 << NF) - 1;
			comp[i] = n[i] < 0 ? -q[NF:0] : q[NF:0];
		end
		res.nx = comp[0];
		res.ny = comp[1];
		res.nz = comp[2];
		res.deg = 1'b0;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic send_face(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
			coord_t bz, coord_t cx, coord_t cy, coord_t cz);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_x <= ax; a_y <= ay; a_z <= az;
		b_x <= bx; b_y <= by; b_z <= bz;
		c_x <= cx; c_y <= cy; c_z <= cz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_normals = {pending_normals, face_normal(ax, ay, az, bx, by, bz, cx, cy, cz)};
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_triangle_face_normal_top: errors");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_normals.size() == 0) begin
				report_mismatch("unexpected beat", 0, 0);
			end else begin
				normal_t want;
				want = pending_normals.pop_front();
				if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
				if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
				if (normal_z !== want.nz) report_mismatch("normal_z", normal_z, want.nz);
				if (degenerate !== want.deg) report_mismatch("degenerate", degenerate, want.deg);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic coord_t rand_coord();
		case ($urandom_range(5))
			0: return coord_t'($urandom_range(7)) - coord_t'(4);
			1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			2: return coord_t'($urandom_range(511)) - coord_t'(256);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		coord_t mx = 16'sh7fff;
		coord_t mn = 16'sh8000;
		send_face(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_face(5, 5, 5, 5, 5, 5, 5, 5, 5);
		send_face(0, 0, 0, 256, 256, 256, 512, 512, 512);
		send_face(0, 0, 0, 256, 0, 0, 0, 256, 0);
		send_face(0, 0, 0, 0, 256, 0, 256, 0, 0);
		send_face(0, 0, 0, 0, 1, 0, 0, 0, 1);
		send_face(0, 0, 0, 0, 0, 1, 1, 0, 0);
		send_face(mn, mn, mn, mx, mn, mn, mn, mx, mn);
		send_face(mx, mx, mx, mn, mx, mx, mx, mn, mx);
		send_face(mn, mn, mn, mx, mx, mx, mn, mx, mn);
		send_face(mx, mn, mx, mn, mx, mn, mx, mx, mn);
		send_face(0, 0, 0, 1, 1, 0, 1, 0, 1);
		send_face(0, 0, 0, 1, 2, 3, 4, 5, 7);
		send_face(mn, 0, mx, mx, mn, 0, 0, mx, mn);
		send_face(-1, -1, -1, 1, -1, -1, -1, 1, -1);
		send_face(0, 0, 0, mx, 0, 0, 1, 1, 0);
		send_face(mn, mn, 0, mx, mx, 0, mn, mx, 1);
		send_face(0, 0, 0, 1, 0, 0, 0, 0, 0);
		go_idle();
	endtask

	task automatic test_random(int count, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				coord_t ax, ay, az, dx, dy, dz;
				coord_t k;
				ax = rand_coord(); ay = rand_coord(); az = rand_coord();
				dx = coord_t'($urandom_range(15)) - coord_t'(8);
				dy = coord_t'($urandom_range(15)) - coord_t'(8);
				dz = coord_t'($urandom_range(15)) - coord_t'(8);
				k = coord_t'($urandom_range(3));
				send_face(ax, ay, az, ax + dx, ay + dy, az + dz,
					ax + k * dx, ay + k * dy, az + k * dz);
			end else begin
				send_face(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), rand_coord());
			end
		end
		go_idle();
	endtask

	task automatic test_drain_pause();
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(350, 0, 0);
		test_drain_pause();
		test_random(350, 76, 0);
		test_random(350, 0, 76);
		test_drain_pause();
		test_random(350, 28, 28);
		stall_pct = 0;
		test_drain_pause();
		if (errors == 0) begin
			$display("tb_triangle_face_normal_top: clean");
		end else begin
			$display("tb_triangle_face_normal_top: errors");
		end
		$finish;
	end

endmodule
